/* src/length_prefixed_deframer_top_defines.svh */
// Assertion macros shared by the deframer checker.
`ifndef LENGTH_PREFIXED_DEFRAMER_TOP_DEFINES_SVH
`define LENGTH_PREFIXED_DEFRAMER_TOP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define LPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/lpd_pkg.sv */
// Shared types and constants of the length-prefixed deframer.
`default_nettype none
package lpd_pkg;

  localparam int HEADER_BYTES = 4;
  localparam logic [31:0] MAX_FRAME_RESET = 32'd104857600;
  localparam logic [31:0] BASE_RESET = 32'h1000_0000;

  typedef enum logic [2:0] {
    ST_HEADER  = 3'd0,
    ST_STORED  = 3'd1,
    ST_DISCARD = 3'd2,
    ST_BADLEN  = 3'd3,
    ST_RESTART = 3'd4
  } status_t;

  typedef enum logic {
    CFG_MAX_FRAME = 1'b0,
    CFG_BASE      = 1'b1
  } cfg_index_t;

endpackage
`default_nettype wire

/* src/length_prefixed_deframer_top.sv */
// Top level of the length-prefixed deframer: header decode and payload addressing.
//
// The input channel carries one stream byte or a restart marker per transaction,
// accepted when byte_valid is high and byte_stall is low. Each accepted
// transaction yields exactly one result transaction on the output channel,
// accepted when result_valid is high and result_stall is low.
// The first bytes form a big-endian length. A zero length or one above
// max_frame_bytes reports a bad length and header collection starts over.
// The payload bytes then leave with store_addr set to buffer_base plus the
// running count, and the last one raises frame_done.
// Each result is held in a single output register. The block takes one
// byte every cycle while the output moves; the state update and the result
// are both computed from the accepted byte ahead of the output register.
// When the receiver stalls with a result held, byte_stall rises in the same
// cycle and the held result does not change.
// The configuration port is always ready and should be written only while idle.
// Reset restores both registers to their defaults, clears the decoder state,
// and empties the output register.
`default_nettype none
module length_prefixed_deframer_top (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 byte_valid,
  output logic                      byte_stall,
  input  wire logic                 req_type,
  input  wire logic [7:0]           data_byte,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output lpd_pkg::status_t          status,
  output logic                      store_valid,
  output logic [31:0]               store_addr,
  output logic [7:0]                store_data,
  output logic [31:0]               frame_length,
  output logic                      frame_done,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic                 cfg_index,
  input  wire logic [31:0]          cfg_data
);
  import lpd_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DISCARD = 2'd2
  } phase_t;

  phase_t      phase;
  phase_t      phase_next;
  logic [2:0]  header_count;
  logic [2:0]  header_count_next;
  logic [31:0] length_shift;
  logic [31:0] length_shift_next;
  logic [31:0] payload_count;
  logic [31:0] payload_count_next;
  logic [31:0] max_frame_bytes;
  logic [31:0] buffer_base;

  status_t     status_next;
  logic        store_valid_next;
  logic [31:0] store_addr_next;
  logic [7:0]  store_data_next;
  logic [31:0] frame_length_next;
  logic        frame_done_next;

  logic        accept;
  logic [2:0]  header_inc;
  logic [31:0] shifted;
  logic        header_complete;
  logic [31:0] count_inc;

  assign byte_stall = result_valid && result_stall;
  assign accept     = byte_valid && !byte_stall;
  assign cfg_ready  = 1'b1;

  assign header_inc      = header_count + 3'd1;
  assign shifted         = {length_shift[23:0], data_byte};
  assign header_complete = (header_inc == 3'd0) || ({1'b0, header_inc} >= 4'(HEADER_BYTES));
  assign count_inc       = payload_count + 32'd1;

  always_comb begin
    phase_next         = phase;
    header_count_next  = header_count;
    length_shift_next  = length_shift;
    payload_count_next = payload_count;
    status_next        = ST_DISCARD;
    store_valid_next   = 1'b0;
    store_addr_next    = '0;
    store_data_next    = '0;
    frame_length_next  = '0;
    frame_done_next    = 1'b0;
    if (req_type) begin
      phase_next         = PH_HEADER;
      header_count_next  = '0;
      length_shift_next  = '0;
      payload_count_next = '0;
      status_next        = ST_RESTART;
    end else begin
      case (phase)
        PH_HEADER: begin
          length_shift_next = shifted;
          header_count_next = header_inc;
          status_next       = ST_HEADER;
          if (header_complete) begin
            frame_length_next  = shifted;
            header_count_next  = '0;
            payload_count_next = '0;
            if ((shifted == 32'd0) || (shifted > max_frame_bytes)) begin
              phase_next        = PH_HEADER;
              length_shift_next = '0;
              status_next       = ST_BADLEN;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          payload_count_next = count_inc;
          status_next        = ST_STORED;
          store_valid_next   = 1'b1;
          store_addr_next    = buffer_base + payload_count;
          store_data_next    = data_byte;
          frame_length_next  = length_shift;
          if (count_inc == length_shift) begin
            frame_done_next = 1'b1;
            phase_next      = PH_DISCARD;
          end
        end
        default: begin
          status_next       = ST_DISCARD;
          frame_length_next = length_shift;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      header_count    <= '0;
      length_shift    <= '0;
      payload_count   <= '0;
      max_frame_bytes <= MAX_FRAME_RESET;
      buffer_base     <= BASE_RESET;
      result_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'(cfg_index))
          CFG_MAX_FRAME: max_frame_bytes <= cfg_data;
          CFG_BASE:      buffer_base     <= cfg_data;
          default:       buffer_base     <= buffer_base;
        endcase
      end
      if (accept) begin
        phase         <= phase_next;
        header_count  <= header_count_next;
        length_shift  <= length_shift_next;
        payload_count <= payload_count_next;
        result_valid  <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status       <= status_next;
      store_valid  <= store_valid_next;
      store_addr   <= store_addr_next;
      store_data   <= store_data_next;
      frame_length <= frame_length_next;
      frame_done   <= frame_done_next;
    end
  end

endmodule
`default_nettype wire

/* src/lpd_checker.sv */
// Port-level checker for the length-prefixed deframer, bound to its top level.
`default_nettype none
`include "length_prefixed_deframer_top_defines.svh"
module lpd_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             result_valid,
  input wire logic             result_stall,
  input wire lpd_pkg::status_t status,
  input wire logic             store_valid,
  input wire logic [31:0]      store_addr,
  input wire logic [31:0]      frame_length,
  input wire logic             frame_done
);
  import lpd_pkg::*;

  logic        store_ok;
  logic        done_valid;
  logic        is_restart;
  logic        is_discard;
  logic        clean;
  logic        has_length;
  logic        held;
  logic [66:0] held_data;

  assign store_ok   = store_valid == (status == ST_STORED);
  assign done_valid = result_valid && frame_done;
  assign is_restart = result_valid && (status == ST_RESTART);
  assign is_discard = result_valid && (status == ST_DISCARD);
  assign clean      = (frame_length == 32'd0) && !frame_done;
  assign has_length = frame_length != 32'd0;
  assign held       = result_valid && result_stall;
  assign held_data  = {status, store_addr, frame_length};

  `LPD_ASSERT_NOW(a_store_matches_status, result_valid, store_ok, "store flag wrong")
  `LPD_ASSERT_NOW(a_done_needs_store, done_valid, store_valid, "frame_done without store")
  `LPD_ASSERT_NOW(a_restart_clean, is_restart, clean, "restart result carries frame data")
  `LPD_ASSERT_NOW(a_discard_has_length, is_discard, has_length, "discard without length")
  `LPD_ASSERT_NEXT(a_stall_holds, held, result_valid && $stable(held_data), "stall not held")

endmodule

bind length_prefixed_deframer_top lpd_checker u_lpd_checker (.*);
`default_nettype wire
